// File: sv/hfbe_pkg.sv
// ----------------------------------------------------------------------------
// hfbe_pkg
// Shared types, character codes and helpers for the header field body
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package hfbe_pkg;

   localparam int NAME_BYTES_DEFAULT = 32;
   localparam int HOLD_DEPTH_DEFAULT = 16;

   // name register file holds 32 bytes; positions beyond read as zero
   localparam int NAME_REG_BYTES = 32;
   localparam int NAME_IDX_W     = 5;
   localparam int LEN_W          = 7;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_MID_LOW  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_MID_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_HIGH     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_LENGTH   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OCCURRENCE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_FOLDING = 3'd6;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_MATCH,
      PH_NAME_DONE,
      PH_SKIP,
      PH_LEAD,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FOLD,
      BK_WORK
   } back_state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PUSH_WS,
      ACT_FLUSH
   } act_type;

   // one unit of work for the back end
   typedef struct packed {
      logic       push_cr;
      act_type    act;
      logic [7:0] data;
      logic       last;
      logic       found;
   } cmd_type;

   typedef struct packed {
      logic [8*NAME_REG_BYTES-1:0] name_chars;
      logic [5:0]                  name_length;
      logic [7:0]                  occurrence_wanted;
      logic                        strip_folding;
   } cfg_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c inside {CHAR_SPACE, [8'd9:8'd13]};
   endfunction

   function automatic logic is_tab_sp(input logic [7:0] c);
      return c inside {CHAR_SPACE, CHAR_TAB};
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
   endfunction

endpackage

`default_nettype wire

// File: sv/header_field_body_extractor.sv
// Bytes outside the wanted body are taken one per cycle while the command queue
// is not full. Each body or end byte takes the back end longer for every held
// byte released and for a kept CR, which goes into the hold first; output stalls
// delay results further, and a 4-entry command queue lets the front run ahead.
// Reset: synchronous, active high; clears all control state, not the hold memory.
// ----------------------------------------------------------------------------
// header_field_body_extractor
// Extracts the body of the chosen occurrence of a named mail header field
// from a stream of raw header bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module header_field_body_extractor #(
   parameter int NAME_BYTES = hfbe_pkg::NAME_BYTES_DEFAULT,
   parameter int HOLD_DEPTH = hfbe_pkg::HOLD_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [hfbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hfbe_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_header_byte,
   input  wire logic                             req_final_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [7:0]                            rsp_body_byte,
   output logic                                  rsp_byte_present,
   output logic                                  rsp_found,
   output logic                                  rsp_end_of_body
);
   import hfbe_pkg::*;

   cfg_type cfg_ff;
   logic    q_full, q_push, q_pop, q_empty;
   cmd_type q_in_data, q_out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NAME_LOW:      cfg_ff.name_chars[63:0]    <= csr_write_data;
            CSR_NAME_MID_LOW:  cfg_ff.name_chars[127:64]  <= csr_write_data;
            CSR_NAME_MID_HIGH: cfg_ff.name_chars[191:128] <= csr_write_data;
            CSR_NAME_HIGH:     cfg_ff.name_chars[255:192] <= csr_write_data;
            CSR_NAME_LENGTH:   cfg_ff.name_length         <= csr_write_data[5:0];
            CSR_OCCURRENCE:    cfg_ff.occurrence_wanted   <= csr_write_data[7:0];
            CSR_STRIP_FOLDING: cfg_ff.strip_folding       <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   hfbe_front #(
      .NAME_BYTES (NAME_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_header_byte (req_header_byte),
      .req_final_byte  (req_final_byte),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_in_data)
   );

   hfbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   hfbe_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_out_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_body_byte    (rsp_body_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_found        (rsp_found),
      .rsp_end_of_body  (rsp_end_of_body)
   );

endmodule

`default_nettype wire

// File: sv/hfbe_front.sv
// ----------------------------------------------------------------------------
// hfbe_front
// Accepts header bytes, tracks line starts, name matching and occurrence
// counting, and turns body bytes and the body's end into hold-buffer commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_front #(
   parameter int NAME_BYTES = hfbe_pkg::NAME_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hfbe_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_header_byte,
   input  wire logic              req_final_byte,
   input  wire logic              q_full,
   output logic                   q_push,
   output hfbe_pkg::cmd_type      q_data
);
   import hfbe_pkg::*;

   localparam int PW = $clog2(NAME_BYTES + 1);
   localparam logic [LEN_W-1:0] NAME_LIMIT = LEN_W'(NAME_BYTES);

   phase_type        phase_ff, phase_in, phase_step;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [7:0]       occ_ff, occ_in, occ_cur;
   logic [7:0]       prev_ff, prev_in;
   logic             fresh_ff, fresh_in;

   logic             acc;
   logic [7:0]       c;
   logic [LEN_W-1:0] len;
   logic [NAME_IDX_W-1:0] name_idx;
   logic [7:0]       name_pos_byte;
   logic             hit_pos, hit_zero, pos_done, cr_restart;
   logic [PW-1:0]    pos_inc;
   logic [7:0]       body_p;
   logic             body_end;
   cmd_type          cmd;
   logic             cmd_needed;

   assign req_ready = !q_full;
   assign acc       = req_valid && !q_full;
   assign c         = req_header_byte;
   assign occ_cur   = fresh_ff ? cfg.occurrence_wanted : occ_ff;

   assign len = (LEN_W'(cfg.name_length) > NAME_LIMIT) ? NAME_LIMIT
                                                        : LEN_W'(cfg.name_length);

   assign name_idx      = NAME_IDX_W'(pos_ff);
   assign name_pos_byte = (LEN_W'(pos_ff) < LEN_W'(NAME_REG_BYTES))
                          ? cfg.name_chars[{name_idx, 3'b000} +: 8] : 8'd0;

   assign pos_inc  = pos_ff + PW'(1);
   assign hit_pos  = (LEN_W'(pos_ff) < len) && (to_lower(c) == to_lower(name_pos_byte));
   assign pos_done = (LEN_W'(pos_inc) == len);
   assign hit_zero = (len != '0) && (to_lower(c) == to_lower(cfg.name_chars[7:0]));
   // a lone CR ends the line: this byte starts a new one
   assign cr_restart = (prev_ff == CHAR_CR) && (c != CHAR_LF);

   assign body_p   = (phase_ff == PH_BODY) ? prev_ff : CHAR_SPACE;
   assign body_end = ((body_p == CHAR_LF) && !is_tab_sp(c)) ||
                     ((body_p == CHAR_CR) && (c != CHAR_LF) && !is_tab_sp(c));

   // next phase
   always_comb begin
      phase_step = phase_ff;
      case (phase_ff)
         PH_MATCH: begin
            if (hit_pos) begin
               if (pos_done) phase_step = PH_NAME_DONE;
            end else if (c == CHAR_LF) begin
               phase_step = PH_MATCH;
            end else begin
               phase_step = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (cr_restart) begin
               if (hit_zero) begin
                  phase_step = (len == LEN_W'(1)) ? PH_NAME_DONE : PH_MATCH;
               end else begin
                  phase_step = PH_SKIP;
               end
            end else if (c == CHAR_LF) begin
               phase_step = PH_MATCH;
            end
         end
         PH_NAME_DONE: begin
            if (!is_ws(c)) begin
               phase_step = (c == CHAR_COLON && occ_cur == 8'd0) ? PH_LEAD : PH_SKIP;
            end
         end
         PH_LEAD: begin
            if (!is_ws(c)) phase_step = body_end ? PH_DONE : PH_BODY;
         end
         PH_BODY: begin
            if (body_end) phase_step = PH_DONE;
         end
         PH_DONE: phase_step = PH_DONE;
         default: phase_step = PH_MATCH;
      endcase

      if (!acc) begin
         phase_in = phase_ff;
      end else if (req_final_byte) begin
         phase_in = PH_MATCH;
      end else begin
         phase_in = phase_step;
      end
   end

   // byte-level state and command
   always_comb begin
      pos_in   = pos_ff;
      prev_in  = prev_ff;
      occ_in   = occ_cur;
      fresh_in = 1'b0;
      cmd      = '{push_cr: 1'b0, act: ACT_NONE, data: c, last: 1'b0, found: 1'b0};

      case (phase_ff)
         PH_MATCH: begin
            prev_in = c;
            pos_in  = hit_pos ? pos_inc : '0;
         end
         PH_SKIP: begin
            prev_in = c;
            pos_in  = (cr_restart && hit_zero) ? PW'(1) : '0;
         end
         PH_NAME_DONE: begin
            if (!is_ws(c)) begin
               prev_in = c;
               if (c == CHAR_COLON && occ_cur != 8'd0) occ_in = occ_cur - 8'd1;
            end
         end
         PH_LEAD, PH_BODY: begin
            if (phase_ff == PH_BODY || !is_ws(c)) begin
               if (body_end) begin
                  cmd.last  = 1'b1;
                  cmd.found = 1'b1;
               end else begin
                  prev_in = c;
                  if (cfg.strip_folding) begin
                     // drop an LF line break with its CR and the fold character after it
                     if (c != CHAR_CR && c != CHAR_LF && body_p != CHAR_LF) begin
                        cmd.push_cr = (body_p == CHAR_CR);
                        cmd.act     = is_ws(c) ? ACT_PUSH_WS : ACT_FLUSH;
                     end
                  end else begin
                     cmd.act = is_ws(c) ? ACT_PUSH_WS : ACT_FLUSH;
                  end
               end
            end
         end
         default: ;
      endcase

      if (req_final_byte) begin
         if (phase_step != PH_DONE) begin
            cmd.last  = 1'b1;
            cmd.found = (phase_step == PH_LEAD) || (phase_step == PH_BODY);
         end
         pos_in   = '0;
         prev_in  = CHAR_SPACE;
         fresh_in = 1'b1;
      end
   end

   assign cmd_needed = cmd.push_cr || (cmd.act != ACT_NONE) || cmd.last;
   assign q_push     = acc && cmd_needed;
   assign q_data     = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MATCH;
         pos_ff   <= '0;
         occ_ff   <= '0;
         prev_ff  <= CHAR_SPACE;
         fresh_ff <= 1'b1;
      end else if (acc) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         occ_ff   <= occ_in;
         prev_ff  <= prev_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/hfbe_queue.sv
// ----------------------------------------------------------------------------
// hfbe_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire hfbe_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output hfbe_pkg::cmd_type      pop_data,
   output logic                   empty
);
   import hfbe_pkg::*;

   localparam int QPW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push, do_pop;

   assign full     = (count_ff == QCW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCW'(1);
      if (!do_push && do_pop) count_in = count_ff - QCW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPW'(1);
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/hfbe_back.sv
// ----------------------------------------------------------------------------
// hfbe_back
// Runs hold-buffer commands: holds trailing whitespace, releases it ahead of
// body bytes or on overflow, and marks the end of the extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbe_back #(
   parameter int HOLD_DEPTH = hfbe_pkg::HOLD_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire hfbe_pkg::cmd_type q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_body_byte,
   output logic                   rsp_byte_present,
   output logic                   rsp_found,
   output logic                   rsp_end_of_body
);
   import hfbe_pkg::*;

   localparam int HW = $clog2(HOLD_DEPTH);
   localparam int CW = $clog2(HOLD_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int RW = $clog2(HOLD_DEPTH + 3);
   localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(HOLD_DEPTH);

   function automatic logic [HW-1:0] wrap_idx(input logic [SW-1:0] s);
      return (s >= DEPTH_S) ? HW'(s - DEPTH_S) : HW'(s);
   endfunction

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [HW-1:0]  head_ff, head_in, head_next, tail;
   logic [CW-1:0]  count_ff, count_in;
   logic [RW-1:0]  rem_ff, rem_in, rem_load;
   logic [7:0]     hold_mem [HOLD_DEPTH];
   logic [7:0]     rd_ff;

   logic           wr_en;
   logic [HW-1:0]  wr_addr;
   logic [7:0]     wr_data;

   logic           out_free, hold_full, mark;
   logic           emit, emit_present, emit_found, emit_last;
   logic [7:0]     emit_byte;
   logic           fold_done, work_done;

   logic           ld_cr_emit;
   logic [CW-1:0]  ld_count1;
   logic [RW-1:0]  ld_rest;

   logic           rsp_valid_ff;
   logic [7:0]     body_ff;
   logic           present_ff, found_ff, end_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hold_full = (count_ff == DEPTH_C);
   assign head_next = wrap_idx(SW'(head_ff) + SW'(1));
   assign tail      = wrap_idx(SW'(head_ff) + SW'(count_ff));
   assign mark      = cmd_ff.last && (rem_ff == RW'(1));

   // number of data-byte results the incoming command will produce
   always_comb begin
      ld_cr_emit = q_data.push_cr && hold_full;
      ld_count1  = (q_data.push_cr && !hold_full) ? count_ff + CW'(1) : count_ff;
      case (q_data.act)
         ACT_PUSH_WS: ld_rest = RW'(ld_count1 == DEPTH_C);
         ACT_FLUSH:   ld_rest = RW'(ld_count1) + RW'(1);
         default:     ld_rest = '0;
      endcase
      rem_load = RW'(ld_cr_emit) + ld_rest;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) state_in = q_data.push_cr ? BK_FOLD : BK_WORK;
         end
         BK_FOLD: begin
            if (fold_done) state_in = BK_WORK;
         end
         BK_WORK: begin
            if (work_done) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath actions
   always_comb begin
      q_pop        = 1'b0;
      cmd_in       = cmd_ff;
      rem_in       = rem_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = tail;
      wr_data      = CHAR_CR;
      emit         = 1'b0;
      emit_byte    = rd_ff;
      emit_present = 1'b1;
      emit_found   = mark;
      emit_last    = mark;
      fold_done    = 1'b0;
      work_done    = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               rem_in = rem_load;
            end
         end
         BK_FOLD: begin
            if (hold_full) begin
               // overflow: release the oldest and reuse its slot
               if (out_free) begin
                  emit      = 1'b1;
                  head_in   = head_next;
                  wr_en     = 1'b1;
                  wr_addr   = head_ff;
                  rem_in    = rem_ff - RW'(1);
                  fold_done = 1'b1;
               end
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CW'(1);
               fold_done = 1'b1;
            end
         end
         BK_WORK: begin
            case (cmd_ff.act)
               ACT_PUSH_WS: begin
                  wr_data = cmd_ff.data;
                  if (hold_full) begin
                     if (out_free) begin
                        emit      = 1'b1;
                        head_in   = head_next;
                        wr_en     = 1'b1;
                        wr_addr   = head_ff;
                        rem_in    = rem_ff - RW'(1);
                        work_done = 1'b1;
                     end
                  end else if (!cmd_ff.last || out_free) begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + CW'(1);
                     work_done = 1'b1;
                     if (cmd_ff.last) begin
                        emit         = 1'b1;
                        emit_byte    = 8'd0;
                        emit_present = 1'b0;
                        emit_found   = cmd_ff.found;
                        emit_last    = 1'b1;
                     end
                  end
               end
               ACT_FLUSH: begin
                  if (out_free) begin
                     emit = 1'b1;
                     if (count_ff != '0) begin
                        head_in  = head_next;
                        count_in = count_ff - CW'(1);
                        rem_in   = rem_ff - RW'(1);
                     end else begin
                        emit_byte = cmd_ff.data;
                        work_done = 1'b1;
                     end
                  end
               end
               default: begin
                  if (!cmd_ff.last) begin
                     work_done = 1'b1;
                  end else if (out_free) begin
                     emit         = 1'b1;
                     emit_byte    = 8'd0;
                     emit_present = 1'b0;
                     emit_found   = cmd_ff.found;
                     emit_last    = 1'b1;
                     work_done    = 1'b1;
                  end
               end
            endcase
            // end of extraction: drop whatever is still held
            if (work_done && cmd_ff.last) begin
               head_in  = '0;
               count_in = '0;
            end
         end
         default: ;
      endcase
   end

   // hold memory, read data always tracks the next head (write-first bypass)
   always_ff @(posedge clock) begin
      if (wr_en) hold_mem[wr_addr] <= wr_data;
      if (wr_en && wr_addr == head_in) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= hold_mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         rem_ff   <= rem_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         body_ff    <= emit_byte;
         present_ff <= emit_present;
         found_ff   <= emit_found;
         end_ff     <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_body_byte    = body_ff;
   assign rsp_byte_present = present_ff;
   assign rsp_found        = found_ff;
   assign rsp_end_of_body  = end_ff;

endmodule

`default_nettype wire
